### design/ssdiv_pkg.sv
// ----------------------------------------------------------------------------
// ssdiv_pkg
// shared types and constants for the saturating signed divider
// ----------------------------------------------------------------------------
package ssdiv_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    // largest positive value, used when the quotient overflows
    localparam logic [DATA_WIDTH-1:0] QUO_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] dividend;
        logic signed [DATA_WIDTH-1:0] divisor;
    } div_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] quotient;
        logic                         divide_by_zero;
    } div_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } ctrl_state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } ctrl_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic last_step;
    } dp_status_t;

endpackage

### design/ssdiv_ctrl.sv
// ----------------------------------------------------------------------------
// ssdiv_ctrl
// sequencer: load, one quotient bit per cycle, then sign fix-up
// ----------------------------------------------------------------------------
module ssdiv_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  ssdiv_pkg::dp_status_t  status,
    output ssdiv_pkg::ctrl_cmd_t   cmd,
    output logic                   busy
);
    import ssdiv_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (status.last_step)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_DIVIDE:
            begin
                cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### design/ssdiv_dp.sv
// ----------------------------------------------------------------------------
// ssdiv_dp
// radix-2 restoring divider on operand magnitudes with sign and saturation
// ----------------------------------------------------------------------------
module ssdiv_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  ssdiv_pkg::ctrl_cmd_t  cmd,
    input  ssdiv_pkg::div_in_t    operands,
    output ssdiv_pkg::dp_status_t status,
    output logic                  done,
    output ssdiv_pkg::div_out_t   result
);
    import ssdiv_pkg::*;

    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] den_reg, den_next;
    logic                  neg_reg, neg_next;
    logic                  zero_reg, zero_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  done_reg, done_next;
    div_out_t              result_reg, result_next;

    logic [DATA_WIDTH-1:0] a_u, b_u, a_mag, b_mag;
    logic [DATA_WIDTH:0]   rem_shift, diff;
    logic [DATA_WIDTH-1:0] q_final;

    assign a_u   = operands.dividend;
    assign b_u   = operands.divisor;
    assign a_mag = a_u[DATA_WIDTH-1] ? (~a_u + DATA_WIDTH'(1)) : a_u;
    assign b_mag = b_u[DATA_WIDTH-1] ? (~b_u + DATA_WIDTH'(1)) : b_u;

    // trial subtract of the divisor from the shifted partial remainder
    assign rem_shift = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff      = rem_shift - {1'b0, den_reg};

    // sign fix-up, zero for a zero divisor, saturate only when a positive result overflows
    always_comb
    begin
        priority if (zero_reg)
        begin
            q_final = '0;
        end
        else if (neg_reg)
        begin
            q_final = ~quo_reg + DATA_WIDTH'(1);
        end
        else if (quo_reg[DATA_WIDTH-1])
        begin
            q_final = QUO_MAX;
        end
        else
        begin
            q_final = quo_reg;
        end
    end

    always_comb
    begin
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        den_next    = den_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        if (cmd.load)
        begin
            quo_next  = a_mag;
            rem_next  = '0;
            den_next  = b_mag;
            neg_next  = a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
            zero_next = (b_u == '0);
            cnt_next  = '0;
        end
        if (cmd.step)
        begin
            if (!diff[DATA_WIDTH])
            begin
                rem_next = diff[DATA_WIDTH-1:0];
            end
            else
            begin
                rem_next = rem_shift[DATA_WIDTH-1:0];
            end
            quo_next = {quo_reg[DATA_WIDTH-2:0], ~diff[DATA_WIDTH]};
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.finish)
        begin
            result_next.quotient       = $signed(q_final);
            result_next.divide_by_zero = zero_reg;
            done_next                  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        zero_reg   <= zero_next;
        result_reg <= result_next;
    end

    assign status.last_step = (cnt_reg == CNT_W'(DATA_WIDTH - 1));
    assign done             = done_reg;
    assign result           = result_reg;

endmodule

### design/saturating_signed_divider_32_core.sv
// ----------------------------------------------------------------------------
// saturating_signed_divider_32_core
// signed divider, quotient truncated toward zero, saturating, zero-divisor flag
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  input     start (taken if !busy)  operands : dividend, divisor
//  output    done strobe, one cycle  result   : quotient, divide_by_zero
//
//  the accepting edge loads the operands; the item then runs DATA_WIDTH
//  subtract/shift steps, one per quotient bit, a sign fix-up step, then
//  the result cycle
//  busy is low again while the result is shown, so the next item can be taken
//  in that cycle; the receiver cannot stall, done marks the result for one cycle only
//  reset clears the sequencer, bit counter and strobe; payload is not reset
// ----------------------------------------------------------------------------
module saturating_signed_divider_32_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  ssdiv_pkg::div_in_t  operands,
    output logic                busy,
    output logic                done,
    output ssdiv_pkg::div_out_t result
);
    import ssdiv_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // sequencer
    ssdiv_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // magnitude divider, sign and saturation
    ssdiv_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .operands (operands),
        .status   (status),
        .done     (done),
        .result   (result)
    );

    // result shows only once the sequencer is back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // an accepted item makes the block busy at once
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("item accepted but block not busy");

    // never two results in a row
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    // zero divisor forces a zero quotient
    a_zero_quotient: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.divide_by_zero) |-> (result.quotient == '0))
        else $error("zero divisor with nonzero quotient");

endmodule

### tb/tb_saturating_signed_divider_32_core.sv
// ----------------------------------------------------------------------------
// tb_saturating_signed_divider_32_core
// self-checking bench for the saturating signed divider core
// ----------------------------------------------------------------------------
// drives operand items through the start/busy handshake and predicts every
// quotient in the bench itself: truncation toward zero, saturation of the
// most negative value over minus one, and the zero-divisor flag
// a directed set covers the corner operands, then random items run in phases
// with and without sender gaps; every done strobe is checked field by field
// against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module tb_saturating_signed_divider_32_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ssdiv_pkg::*;

    localparam int                    ITEMS_PER_PHASE = 650;
    // DATA_WIDTH steps, sign fix-up and the result cycle, with margin
    localparam int                    SETTLE_CYCLES   = DATA_WIDTH + 10;
    localparam int                    MAX_GAP         = 40;
    localparam logic [DATA_WIDTH-1:0] VAL_MIN         = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic [DATA_WIDTH-1:0] VAL_MAX         = QUO_MAX;
    localparam logic [DATA_WIDTH-1:0] VAL_ONE         = 1;
    localparam logic [DATA_WIDTH-1:0] VAL_M1          = '1;
    localparam logic [DATA_WIDTH-1:0] VAL_ZERO        = '0;

    logic     clk      = 1'b0;
    logic     rst_n    = 1'b0;
    logic     start    = 1'b0;
    div_in_t  operands = '0;
    logic     busy;
    logic     done;
    div_out_t result;

    // predicted results, oldest first
    div_out_t quotient_queue[$];
    int       mismatch_count = 0;

    saturating_signed_divider_32_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .operands (operands),
        .busy     (busy),
        .done     (done),
        .result   (result)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // predictor
    // divide the magnitudes without sign, then apply the sign; a positive
    // quotient above the largest value (most negative over minus one) clamps
    // ------------------------------------------------------------------------
    function automatic div_out_t predict_division(input div_in_t op);
        div_out_t              res;
        logic [DATA_WIDTH-1:0] mag_dividend;
        logic [DATA_WIDTH-1:0] mag_divisor;
        logic [DATA_WIDTH-1:0] mag_quotient;
        logic                  negative;
        res = '0;
        if (op.divisor == 0)
        begin
            res.divide_by_zero = 1'b1;
            return res;
        end
        // two's complement negation; the most negative value keeps its
        // pattern, which read without sign is its true magnitude
        mag_dividend = op.dividend[DATA_WIDTH-1] ?
                       (~op.dividend + DATA_WIDTH'(1)) : op.dividend;
        mag_divisor  = op.divisor[DATA_WIDTH-1] ?
                       (~op.divisor + DATA_WIDTH'(1)) : op.divisor;
        mag_quotient = mag_dividend / mag_divisor;
        negative     = op.dividend[DATA_WIDTH-1] ^ op.divisor[DATA_WIDTH-1];
        if (negative)
            res.quotient = ~mag_quotient + DATA_WIDTH'(1);
        else if (mag_quotient > QUO_MAX)
            res.quotient = QUO_MAX;
        else
            res.quotient = mag_quotient;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // result checker
    // done is a single-cycle strobe the bench cannot hold off, so every
    // strobe sampled at an edge is one result
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        div_out_t want;
        if (rst_n && done)
        begin
            if (quotient_queue.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual quotient %0d dbz %0b",
                         $time, result.quotient, result.divide_by_zero);
                mismatch_count++;
            end
            else
            begin
                want = quotient_queue.pop_front();
                if (result.quotient !== want.quotient)
                begin
                    $display("%0t: quotient mismatch, expected %0d (%h) actual %0d (%h)",
                             $time, want.quotient, want.quotient,
                             result.quotient, result.quotient);
                    mismatch_count++;
                end
                if (result.divide_by_zero !== want.divide_by_zero)
                begin
                    $display("%0t: divide_by_zero mismatch, expected %0b actual %0b",
                             $time, want.divide_by_zero, result.divide_by_zero);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // send one item
    // an optional gap with start low comes first; start is left high after
    // acceptance so back-to-back items never lower and raise it in one step
    // ------------------------------------------------------------------------
    task automatic send_item(input div_in_t op, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        operands <= op;
        // taken at the first edge where busy is low
        do
            @(posedge clk);
        while (busy);
        quotient_queue.push_back(predict_division(op));
    endtask

    // drop start and hold off until every predicted result has come
    task automatic wait_for_results();
        start <= 1'b0;
        while (quotient_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic send_pair(input logic [DATA_WIDTH-1:0] a, input logic [DATA_WIDTH-1:0] b);
        div_in_t op;
        op.dividend = a;
        op.divisor  = b;
        send_item(op, 0);
    endtask

    // ------------------------------------------------------------------------
    // directed corner cases
    // ------------------------------------------------------------------------
    task automatic test_corner_operands();
        // most negative over minus one saturates
        send_pair(VAL_MIN, VAL_M1);
        // most negative over one stays most negative
        send_pair(VAL_MIN, VAL_ONE);
        // most negative divisor: one only for an equal dividend
        send_pair(VAL_MIN, VAL_MIN);
        send_pair(VAL_MAX, VAL_MIN);
        send_pair(VAL_M1, VAL_MIN);
        send_pair(32'sd5, VAL_MIN);
        // zero divisor raises the flag
        send_pair(VAL_MIN, VAL_ZERO);
        send_pair(VAL_ZERO, VAL_ZERO);
        send_pair(VAL_MAX, VAL_ZERO);
        send_pair(VAL_M1, VAL_ZERO);
        // zero dividend with a nonzero divisor
        send_pair(VAL_ZERO, 32'sd5);
        send_pair(VAL_ZERO, -32'sd7);
        // largest positive against the extremes
        send_pair(VAL_MAX, VAL_ONE);
        send_pair(VAL_MAX, VAL_M1);
        send_pair(VAL_MAX, VAL_MAX);
        send_pair(VAL_MIN, VAL_MAX);
        send_pair(VAL_ONE, VAL_MAX);
        // truncation toward zero in every sign quadrant
        send_pair(32'sd7, 32'sd2);
        send_pair(-32'sd7, 32'sd2);
        send_pair(32'sd7, -32'sd2);
        send_pair(-32'sd7, -32'sd2);
        send_pair(32'sd3, 32'sd7);
        send_pair(VAL_MIN, -32'sd2);
        send_pair(VAL_M1, VAL_M1);
        wait_for_results();
    endtask

    // one random operand from a mix of shapes
    function automatic logic [DATA_WIDTH-1:0] random_value();
        logic [DATA_WIDTH-1:0] v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4:          v = $urandom_range(200) - 100;
            5:
            begin
                v = VAL_ONE << $urandom_range(DATA_WIDTH - 1);
                if ($urandom_range(1))
                    v = ~v + DATA_WIDTH'(1);
            end
            6:
            begin
                case ($urandom_range(4))
                    0:       v = VAL_MIN;
                    1:       v = VAL_MAX;
                    2:       v = VAL_ZERO;
                    3:       v = VAL_ONE;
                    default: v = VAL_M1;
                endcase
            end
            // varied magnitude: random pattern shifted down by a random amount
            default:    v = $signed($urandom) >>> $urandom_range(DATA_WIDTH - 1);
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------------------
    // random items; idle_pct is the chance of a gap before an item, gap
    // lengths spread past the item time so gaps land on every step
    // ------------------------------------------------------------------------
    task automatic test_random_items(input int count, input int idle_pct);
        div_in_t op;
        int      gap;
        for (int n = 0; n < count; n++)
        begin
            op.dividend = random_value();
            case ($urandom_range(7))
                // divisor near the dividend, so quotients of every size appear
                0, 1:    op.divisor = $signed(op.dividend) >>> $urandom_range(DATA_WIDTH - 1);
                2:       op.divisor = VAL_ZERO;
                default: op.divisor = random_value();
            endcase
            gap = 0;
            if ($urandom_range(99) < idle_pct)
                gap = $urandom_range(1, MAX_GAP);
            send_item(op, gap);
        end
        wait_for_results();
    endtask

    // a few items, full hold-off until all results are back, then a burst
    task automatic test_hold_off();
        div_in_t op;
        for (int n = 0; n < 6; n++)
        begin
            op.dividend = random_value();
            op.divisor  = random_value();
            send_item(op, 0);
        end
        wait_for_results();
        for (int n = 0; n < 6; n++)
        begin
            op.dividend = random_value();
            op.divisor  = random_value();
            send_item(op, 0);
        end
        wait_for_results();
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // the receiver has no stall input, so only the sender gaps vary between
    // the random phases
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_corner_operands();
        test_random_items(ITEMS_PER_PHASE, 0);
        test_hold_off();
        test_random_items(ITEMS_PER_PHASE, 48);
        test_random_items(ITEMS_PER_PHASE, 31);

        if (quotient_queue.size() != 0)
            mismatch_count++;
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // watchdog, well beyond the slowest correct run
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
